// ----- design/jsu_pkg.sv -----
// Package for the JSON string unescape core.
// Holds the decode modes, character codes, burst type and byte helpers.
// No dependencies.
package jsu_pkg;

  // Most bytes one input byte can produce: 'u', three held digits, the byte.
  localparam int MaxResults = 5;
  localparam int CountW     = $clog2(MaxResults + 1);
  localparam int IdxW       = $clog2(MaxResults);
  localparam int HexDepth   = 3;

  // Decode modes
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_U0     = 3'd2;
  localparam logic [2:0] MODE_U3     = 3'd5;

  // Character codes
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_U        = 8'h75;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_B        = 8'h62;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_N        = 8'h6E;
  localparam logic [7:0] CH_R        = 8'h72;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_FF       = 8'h0C;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_TAB      = 8'h09;

  // Decoded bytes of one request, handed from decoder to output buffer
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CountW-1:0]          count;
    logic                       fin;
  } burst_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [7:0] map_escape(input logic [7:0] c);
    unique case (c)
      CH_B:    map_escape = CH_BS;
      CH_F:    map_escape = CH_FF;
      CH_N:    map_escape = CH_LF;
      CH_R:    map_escape = CH_CR;
      CH_T:    map_escape = CH_TAB;
      default: map_escape = c;
    endcase
  endfunction

endpackage

// ----- design/jsu_decode.sv -----
// Escape decoder: decode mode and held hex digits, plus the single-pass
// logic that turns one registered raw byte into a burst. Uses jsu_pkg.
module jsu_decode import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] c,
  input  logic       fin,
  input  logic       take,
  output burst_t     burst
);

  logic [2:0]               mode;
  logic [2:0]               mode_next;
  logic [HexDepth-1:0][7:0] hex_hold;
  logic                     hold_wr;
  logic [1:0]               held;
  logic                     normal_byte;
  logic                     hex;
  logic [CountW-1:0]        n;

  assign held = 2'((mode >= MODE_U3) ? 3'd3 : (mode - MODE_U0));
  assign hex  = is_hex(c);

  // Decode one byte against the current mode
  always_comb begin
    burst.bytes = '0;
    burst.fin   = fin;
    n           = '0;
    normal_byte = 1'b0;
    hold_wr     = 1'b0;
    mode_next   = MODE_NORMAL;
    if (mode == MODE_NORMAL) begin
      normal_byte = 1'b1;
    end else if (mode == MODE_ESC) begin
      if (c == CH_U && !fin) begin
        mode_next = MODE_U0;
      end else begin
        burst.bytes[0] = map_escape(c);
        n              = CountW'(1);
      end
    end else begin
      if (hex && held == 2'd3) begin
        burst.bytes[0] = CH_QUESTION;
        n              = CountW'(1);
      end else if (hex && !fin) begin
        hold_wr   = 1'b1;
        mode_next = mode + 3'd1;
      end else begin
        // Broken unicode escape: 'u', the held digits, then the byte
        burst.bytes[0] = CH_U;
        for (int k = 1; k <= HexDepth; k++) begin
          burst.bytes[k] = (k - 1 < int'(held)) ? hex_hold[k-1] : c;
        end
        burst.bytes[MaxResults-1] = c;
        n           = CountW'(held) + CountW'(1);
        normal_byte = 1'b1;
      end
    end
    if (normal_byte) begin
      if (c == CH_BSLASH && !fin) begin
        mode_next = MODE_ESC;
      end else begin
        if (mode == MODE_NORMAL) begin
          burst.bytes[0] = c;
        end
        n = n + CountW'(1);
      end
    end
    if (fin) begin
      mode_next = MODE_NORMAL;
    end
    burst.count = n;
  end

  // Advance mode when the byte is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
    end else if (take) begin
      mode <= mode_next;
    end
  end

  // Hold hex digits
  always_ff @(posedge clk) begin
    if (take && hold_wr) begin
      hex_hold[held] <= c;
    end
  end

endmodule

// ----- design/jsu_burst.sv -----
// Result buffer: holds one decoded burst and drains it one byte per cycle
// onto the output channel while out_stall is low. Uses jsu_pkg.
module jsu_burst import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  burst_t     burst,
  input  logic       load,
  output logic       loadable,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] decoded_byte,
  output logic       run_end,
  output logic       string_end
);

  burst_t          buffer;
  logic            full;
  logic [IdxW-1:0] idx;
  logic            pop;

  assign out_valid    = full;
  assign decoded_byte = buffer.bytes[idx];
  assign run_end      = (CountW'(idx) + CountW'(1)) == buffer.count;
  assign string_end   = run_end && buffer.fin;
  assign pop          = full && !out_stall;
  assign loadable     = !full || (pop && run_end);

  // Track occupancy and drain position
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= '0;
    end else if (pop) begin
      if (run_end) begin
        full <= 1'b0;
      end
      idx <= idx + IdxW'(1);
    end
  end

  // Capture burst payload
  always_ff @(posedge clk) begin
    if (load) begin
      buffer <= burst;
    end
  end

endmodule

// ----- design/json_string_unescape_core.sv -----
// Top level of the JSON string unescape core.
// Instantiates jsu_decode and jsu_burst; uses jsu_pkg.
//
//   channel   handshake              payload
//   in        in_valid / in_stall    raw_byte, final_byte
//   out       out_valid / out_stall  decoded_byte, run_end, string_end
//
// One raw byte is taken per cycle unless in_stall is set. A request is held in
// the input register, decoded there and moved into the result buffer, which
// sends one decoded byte per cycle unless out_stall is set; the next request
// waits until the last byte is sent. Requests with no result never wait on the
// output. Reset returns the decoder to normal mode and empties both registers.
module json_string_unescape_core import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] raw_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] decoded_byte,
  output logic       run_end,
  output logic       string_end
);

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_fin;
  logic       take;
  logic       load;
  logic       loadable;
  burst_t     burst;

  // Take the held request when it makes no bytes or the buffer frees up
  assign take     = in_full && (burst.count == '0 || loadable);
  assign load     = take && burst.count != '0;
  assign in_stall = in_full && !take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= (in_valid && !in_stall) || in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= raw_byte;
      in_fin  <= final_byte;
    end
  end

  jsu_decode u_decode (
    .clk   (clk),
    .rst   (rst),
    .c     (in_byte),
    .fin   (in_fin),
    .take  (take),
    .burst (burst)
  );

  jsu_burst u_burst (
    .clk          (clk),
    .rst          (rst),
    .burst        (burst),
    .load         (load),
    .loadable     (loadable),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .decoded_byte (decoded_byte),
    .run_end      (run_end),
    .string_end   (string_end)
  );

endmodule

// ----- tb/sv/jsu_checker.sv -----
// Result checker for json_string_unescape_core: watches both channels.
// Decodes each accepted request on its own and compares every decoded byte.
// Depends on jsu_pkg for the decode modes and character codes.
module jsu_checker import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] raw_byte,
  input  logic       final_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] decoded_byte,
  input  logic       run_end,
  input  logic       string_end,
  output int         fail_count,
  output int         pending_count,
  output int         checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] DIGIT_LO = 8'h30;
  localparam logic [7:0] DIGIT_HI = 8'h39;
  localparam logic [7:0] LOWER_LO = 8'h61;
  localparam logic [7:0] LOWER_HI = 8'h66;
  localparam logic [7:0] UPPER_LO = 8'h41;
  localparam logic [7:0] UPPER_HI = 8'h46;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       string_end;
  } decoded_t;

  decoded_t   decoded_q[$];
  logic [2:0] unesc_mode = MODE_NORMAL;
  logic [7:0] held_digits [HexDepth];
  int         mismatches   = 0;
  int         results_seen = 0;

  function automatic bit hex_digit(input logic [7:0] c);
    return c inside {[DIGIT_LO:DIGIT_HI], [LOWER_LO:LOWER_HI], [UPPER_LO:UPPER_HI]};
  endfunction

  function automatic logic [7:0] escape_char(input logic [7:0] c);
    unique case (c)
      CH_B:    return CH_BS;
      CH_F:    return CH_FF;
      CH_N:    return CH_LF;
      CH_R:    return CH_CR;
      CH_T:    return CH_TAB;
      default: return c;
    endcase
  endfunction

  // Decode one request and queue the bytes it should produce
  task automatic unescape_request(input logic [7:0] c, input logic fin);
    logic [7:0] burst[$];
    bit         plain;
    int         held;
    decoded_t   item;
    plain = 1'b0;
    if (unesc_mode == MODE_NORMAL) begin
      plain = 1'b1;
    end else if (unesc_mode == MODE_ESC) begin
      if (c == CH_U && !fin) begin
        unesc_mode = MODE_U0;
      end else begin
        burst.insert(burst.size(), escape_char(c));
        unesc_mode = MODE_NORMAL;
      end
    end else begin
      held = int'(unesc_mode) - int'(MODE_U0);
      if (held > HexDepth) held = HexDepth;
      if (hex_digit(c) && held == HexDepth) begin
        burst.insert(burst.size(), CH_QUESTION);
        unesc_mode = MODE_NORMAL;
      end else if (hex_digit(c) && !fin) begin
        held_digits[held] = c;
        unesc_mode = MODE_U0 + 3'(held + 1);
      end else begin
        // broken unicode escape: replay what was held, then treat c as plain
        burst.insert(burst.size(), CH_U);
        for (int i = 0; i < held; i++) burst.insert(burst.size(), held_digits[i]);
        unesc_mode = MODE_NORMAL;
        plain = 1'b1;
      end
    end

    if (plain) begin
      if (c == CH_BSLASH && !fin) begin
        unesc_mode = MODE_ESC;
      end else begin
        burst.insert(burst.size(), c);
        unesc_mode = MODE_NORMAL;
      end
    end

    if (fin) unesc_mode = MODE_NORMAL;

    foreach (burst[k]) begin
      item.data       = burst[k];
      item.run_end    = (k == burst.size() - 1);
      item.string_end = item.run_end && fin;
      decoded_q.insert(decoded_q.size(), item);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH result %0d %s: got %h want %h", results_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      unesc_mode = MODE_NORMAL;
      decoded_q.delete();
    end else begin
      // compare an accepted result with the oldest expectation
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("with nothing expected, byte", decoded_byte, 8'h00);
        end else begin
          want = decoded_q.pop_front();
          if (decoded_byte !== want.data)
            report_mismatch("decoded_byte", decoded_byte, want.data);
          if (run_end !== want.run_end)
            report_mismatch("run_end", 8'(run_end), 8'(want.run_end));
          if (string_end !== want.string_end)
            report_mismatch("string_end", 8'(string_end), 8'(want.string_end));
        end
        results_seen++;
      end
      // predict an accepted request
      if (in_valid && !in_stall) unescape_request(raw_byte, final_byte);
    end
    fail_count    <= mismatches;
    pending_count <= decoded_q.size();
    checked_count <= results_seen;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for json_string_unescape_core: clock, reset, stimulus, verdict.
// Instantiates the core and jsu_checker; uses jsu_pkg character codes.
module tb_top import jsu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CycleLimit  = 200000;
  localparam int         DrainCycles = 20;
  localparam int         RandomItems = 250;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_G        = 8'h67;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } raw_item_t;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] raw_byte   = 8'h00;
  logic       final_byte = 1'b0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [7:0] decoded_byte;
  logic       run_end;
  logic       string_end;

  int fail_count;
  int pending_count;
  int checked_count;
  int cycle_count = 0;
  int gap_pct     = 0;
  int stall_pct   = 0;

  raw_item_t directed_q[$];
  raw_item_t random_q[$];

  json_string_unescape_core dut (
    .clk, .rst,
    .in_valid, .in_stall, .raw_byte, .final_byte,
    .out_valid, .out_stall, .decoded_byte, .run_end, .string_end
  );

  jsu_checker u_checker (
    .clk, .rst,
    .in_valid, .in_stall, .raw_byte, .final_byte,
    .out_valid, .out_stall, .decoded_byte, .run_end, .string_end,
    .fail_count, .pending_count, .checked_count
  );

  always #5 clk = ~clk;

  // Stall the result side at random
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [7:0] rand_hex();
    string digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(21)];
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]}) c = CH_G;
    return c;
  endfunction

  task automatic add_text(ref raw_item_t q[$], input string s, input bit fin_last);
    for (int i = 0; i < s.len(); i++)
      q.insert(q.size(), '{ch: s[i], last: fin_last && (i == s.len() - 1)});
  endtask

  // Build one literal: mostly well-formed tokens, some noise and cut-offs
  task automatic add_literal(ref raw_item_t q[$]);
    logic [7:0] esc_set [8];
    raw_item_t  lit[$];
    int         tokens;
    int         sel;
    int         digits;
    logic [7:0] c;
    esc_set = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    tokens = $urandom_range(1, 6);
    for (int t = 0; t < tokens; t++) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        c = 8'($urandom_range(255));
        if (c == CH_BSLASH) c = CH_SPACE;
        lit.insert(lit.size(), '{ch: c, last: 1'b0});
      end else if (sel < 50) begin
        lit.insert(lit.size(), '{ch: CH_BSLASH, last: 1'b0});
        c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : esc_set[$urandom_range(7)];
        lit.insert(lit.size(), '{ch: c, last: 1'b0});
      end else if (sel < 85) begin
        // unicode escape, full or broken after fewer than four digits
        digits = (sel < 70) ? 4 : $urandom_range(3);
        lit.insert(lit.size(), '{ch: CH_BSLASH, last: 1'b0});
        lit.insert(lit.size(), '{ch: CH_U, last: 1'b0});
        for (int d = 0; d < digits; d++) lit.insert(lit.size(), '{ch: rand_hex(), last: 1'b0});
        if (digits < 4) lit.insert(lit.size(), '{ch: rand_non_hex(), last: 1'b0});
      end else begin
        c = ($urandom_range(4) == 0) ? CH_BSLASH : 8'($urandom_range(255));
        lit.insert(lit.size(), '{ch: c, last: 1'b0});
      end
    end
    // cut the literal short inside a token now and then
    if (lit.size() > 2 && $urandom_range(4) == 0) begin
      void'(lit.pop_back());
      if ($urandom_range(1) == 0) void'(lit.pop_back());
    end
    if ($urandom_range(19) == 0) lit.insert(lit.size(), '{ch: CH_BSLASH, last: 1'b0});
    lit[lit.size() - 1].last = 1'b1;
    foreach (lit[i]) q.insert(q.size(), lit[i]);
  endtask

  task automatic send_request(input raw_item_t item);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    raw_byte   <= item.ch;
    final_byte <= item.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the sender until every expected byte has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    int literals;
    int third;

    // Directed: byte extremes, escapes, full and broken unicode, final cases
    directed_q.insert(directed_q.size(), '{ch: 8'h00, last: 1'b0});
    add_text(directed_q, "\\u1aF9\\ucde\\n", 1'b0);
    directed_q.insert(directed_q.size(), '{ch: 8'hFF, last: 1'b1});
    add_text(directed_q, "\\u45", 1'b1);
    add_text(directed_q, "\\uAbCD", 1'b1);
    add_text(directed_q, "\\", 1'b1);
    add_text(directed_q, "\\t", 1'b1);

    while (random_q.size() < RandomItems) add_literal(random_q);
    literals = 0;
    foreach (random_q[i]) if (random_q[i].last) literals++;
    third = random_q.size() / 3;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Sender idles lightly, receiver heavily
    gap_pct   = 24;
    stall_pct = 70;
    foreach (directed_q[i]) send_request(directed_q[i]);
    for (int i = 0; i < third; i++) send_request(random_q[i]);
    wait_drained();

    // Roles swapped
    gap_pct   = 70;
    stall_pct = 24;
    for (int i = third; i < 2 * third; i++) send_request(random_q[i]);
    wait_drained();

    // Full rate both ways
    gap_pct   = 0;
    stall_pct = 0;
    for (int i = 2 * third; i < random_q.size(); i++) send_request(random_q[i]);
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d directed and %0d random raw bytes (%0d random literals)",
             directed_q.size(), random_q.size(), literals);
    $display("checked %0d decoded bytes under three idle/stall mixes", checked_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/jsu_pkg.sv
design/jsu_decode.sv
design/jsu_burst.sv
design/json_string_unescape_core.sv
tb/sv/jsu_checker.sv
tb/sv/tb_top.sv
